/* rtl/core/arp_responder_with_cache_assert.svh */
// Assertion macros used by the ARP cache controller RTL.
// Clock and reset are taken from the module that uses the macro.
`ifndef ARP_RESPONDER_WITH_CACHE_ASSERT_SVH
`define ARP_RESPONDER_WITH_CACHE_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define ARPC_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("arpc assertion failed");
`define ARPC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("arpc assertion failed");
`else
`define ARPC_ASSERT_SAME(lbl, ante, cons)
`define ARPC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

/* rtl/core/arpc_pkg.sv */
`timescale 1ns / 1ps

package arpc_pkg;

	localparam int CACHE_ENTRIES = 8;
	localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;

	typedef logic [IDX_W-1:0] idx_t;

	localparam logic [15:0] OP_REQUEST = 16'd1;
	localparam logic [15:0] OP_REPLY   = 16'd2;

	typedef enum logic [2:0] {
		ACT_IGNORED = 3'd0,
		ACT_REPLY   = 3'd1,
		ACT_STORED  = 3'd2,
		ACT_CACHED  = 3'd3,
		ACT_HIT     = 3'd4,
		ACT_MISS    = 3'd5
	} action_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic        mode;
		logic [15:0] opcode;
		logic [47:0] sender_mac;
		logic [31:0] sender_ip;
		logic [31:0] target_ip;
		logic [31:0] query_ip;
	} req_t;

	typedef struct packed {
		action_t     action;
		logic [47:0] mac_addr;
		logic [31:0] ip_addr;
	} rsp_t;

	typedef struct packed {
		logic        en;
		idx_t        addr;
		logic [31:0] ip;
		logic [47:0] mac;
	} cache_wr_t;

endpackage

/* rtl/core/arpc_cache.sv */
`timescale 1ns / 1ps

module arpc_cache (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                rd_en,
	input  arpc_pkg::idx_t      rd_addr,
	input  arpc_pkg::cache_wr_t wr,
	output logic [31:0]         rd_ip,
	output logic [47:0]         rd_mac
);

	logic [31:0] mem_ip  [arpc_pkg::CACHE_ENTRIES];
	logic [47:0] mem_mac [arpc_pkg::CACHE_ENTRIES];
	logic [arpc_pkg::CACHE_ENTRIES-1:0] valid_q;
	logic [31:0] ip_s1;
	logic [47:0] mac_s1;
	logic        vld_s1;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_ip[wr.addr]  <= wr.ip;
			mem_mac[wr.addr] <= wr.mac;
		end
		if (rd_en) begin
			ip_s1  <= mem_ip[rd_addr];
			mac_s1 <= mem_mac[rd_addr];
		end
	end

	// entries never written read back as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			vld_s1  <= 1'b0;
		end else begin
			if (wr.en)
				valid_q[wr.addr] <= 1'b1;
			if (rd_en)
				vld_s1 <= valid_q[rd_addr];
		end
	end

	assign rd_ip  = vld_s1 ? ip_s1 : 32'd0;
	assign rd_mac = vld_s1 ? mac_s1 : 48'd0;

endmodule

/* rtl/core/arpc_ctrl.sv */
`timescale 1ns / 1ps

`include "arp_responder_with_cache_assert.svh"

module arpc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [31:0]         own_ip,
	input  logic                req_valid,
	output logic                req_stall,
	input  arpc_pkg::req_t      req_item,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output arpc_pkg::rsp_t      rsp_item,
	output logic                rd_en,
	output arpc_pkg::idx_t      rd_addr,
	input  logic [31:0]         rd_ip,
	input  logic [47:0]         rd_mac,
	output arpc_pkg::cache_wr_t wr
);

	arpc_pkg::state_t state_q, state_d;
	arpc_pkg::req_t   item_q;
	arpc_pkg::idx_t   idx_q;
	arpc_pkg::idx_t   slot_q;
	arpc_pkg::rsp_t   rsp_q;
	arpc_pkg::rsp_t   res_c;
	logic             rsp_valid_q;
	logic             rd_vld_s1;
	logic             found_q;
	logic [47:0]      mac_q;
	logic             req_fire;
	logic             need_scan;
	logic             idx_last;
	logic [31:0]      key;
	logic             hit_now;
	logic             found_c;
	logic [47:0]      mac_c;
	logic             rsp_ld;
	logic             store_c;

	assign req_fire  = req_valid && !req_stall;
	assign need_scan = req_item.mode ||
		(req_item.opcode == arpc_pkg::OP_REPLY && req_item.target_ip == own_ip);
	assign idx_last  = idx_q == arpc_pkg::idx_t'(arpc_pkg::CACHE_ENTRIES - 1);
	assign key       = item_q.mode ? item_q.query_ip : item_q.sender_ip;

	// compare the entry read in the previous cycle; lowest slot wins
	assign hit_now = rd_vld_s1 && (rd_ip == key);
	assign found_c = found_q || hit_now;
	assign mac_c   = found_q ? mac_q : rd_mac;
	assign rsp_ld  = (state_q == arpc_pkg::ST_FIN) && (!rsp_valid_q || !rsp_stall);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			arpc_pkg::ST_IDLE: begin
				if (req_fire)
					state_d = need_scan ? arpc_pkg::ST_SCAN : arpc_pkg::ST_FIN;
			end
			arpc_pkg::ST_SCAN: begin
				if (idx_last)
					state_d = arpc_pkg::ST_FIN;
			end
			arpc_pkg::ST_FIN: begin
				if (rsp_ld)
					state_d = arpc_pkg::ST_IDLE;
			end
			default: state_d = arpc_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		req_stall = state_q != arpc_pkg::ST_IDLE;
		rd_en     = state_q == arpc_pkg::ST_SCAN;
		rd_addr   = idx_q;
	end

	always_comb begin
		res_c   = '{action: arpc_pkg::ACT_IGNORED, mac_addr: 48'd0, ip_addr: 32'd0};
		store_c = 1'b0;
		priority if (item_q.mode) begin
			if (found_c) begin
				res_c.action   = arpc_pkg::ACT_HIT;
				res_c.mac_addr = mac_c;
			end else begin
				res_c.action  = arpc_pkg::ACT_MISS;
				res_c.ip_addr = item_q.query_ip;
			end
		end else if (item_q.target_ip != own_ip) begin
			res_c.action = arpc_pkg::ACT_IGNORED;
		end else if (item_q.opcode == arpc_pkg::OP_REQUEST) begin
			res_c.action   = arpc_pkg::ACT_REPLY;
			res_c.mac_addr = item_q.sender_mac;
			res_c.ip_addr  = item_q.sender_ip;
		end else if (item_q.opcode == arpc_pkg::OP_REPLY) begin
			if (found_c) begin
				res_c.action = arpc_pkg::ACT_CACHED;
			end else begin
				res_c.action = arpc_pkg::ACT_STORED;
				store_c      = 1'b1;
			end
		end else begin
			res_c.action = arpc_pkg::ACT_IGNORED;
		end
	end

	always_comb begin
		wr.en   = rsp_ld && store_c;
		wr.addr = slot_q;
		wr.ip   = item_q.sender_ip;
		wr.mac  = item_q.sender_mac;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= arpc_pkg::ST_IDLE;
			idx_q       <= '0;
			slot_q      <= '0;
			rd_vld_s1   <= 1'b0;
			found_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= rd_en;
			if (req_fire) begin
				idx_q   <= '0;
				found_q <= 1'b0;
			end else begin
				if (rd_en)
					idx_q <= idx_q + arpc_pkg::idx_t'(1);
				if (hit_now)
					found_q <= 1'b1;
			end
			if (wr.en) begin
				if (slot_q == arpc_pkg::idx_t'(arpc_pkg::CACHE_ENTRIES - 1))
					slot_q <= '0;
				else
					slot_q <= slot_q + arpc_pkg::idx_t'(1);
			end
			if (rsp_ld)
				rsp_valid_q <= 1'b1;
			else if (!rsp_stall)
				rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire)
			item_q <= req_item;
		if (hit_now && !found_q)
			mac_q <= rd_mac;
		if (rsp_ld)
			rsp_q <= res_c;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_item  = rsp_q;

	`ARPC_ASSERT_SAME(a_wr_only_fin, wr.en, state_q == arpc_pkg::ST_FIN)
	`ARPC_ASSERT_NEXT(a_busy_after_take, req_fire, state_q != arpc_pkg::ST_IDLE)
	`ARPC_ASSERT_SAME(a_rd_from_scan, rd_vld_s1, $past(state_q) == arpc_pkg::ST_SCAN)
	`ARPC_ASSERT_SAME(a_slot_range, 1'b1,
		slot_q <= arpc_pkg::idx_t'(arpc_pkg::CACHE_ENTRIES - 1))
	`ARPC_ASSERT_NEXT(a_load_shows, rsp_ld, rsp_valid_q)

endmodule

/* rtl/core/arp_responder_with_cache.sv */
`timescale 1ns / 1ps

// ARP responder with an address cache of CACHE_ENTRIES slots and round-robin
// replacement. One item at a time: a local lookup, or a received reply aimed
// at own_ip, walks the cache one entry per cycle through a single read port
// in the scan state, then moves to the finish state, where its result is
// loaded into the output register, and back to idle, where the next item can
// be taken; every other item goes from idle straight to the finish state. A
// stalled earlier result holds the last step until the output register frees
// up. A new item is taken as soon as the previous result sits in the output
// register, even if that result is still stalled. own_ip may be written
// whenever no item is in flight; the cache reads as all zeros after reset.
module arp_responder_with_cache (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic [31:0]    cfg_own_ip,
	input  logic           req_valid,
	output logic           req_stall,
	input  arpc_pkg::req_t req_item,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output arpc_pkg::rsp_t rsp_item
);

	logic [31:0]         own_ip_q;
	logic                rd_en;
	arpc_pkg::idx_t      rd_addr;
	logic [31:0]         rd_ip;
	logic [47:0]         rd_mac;
	arpc_pkg::cache_wr_t wr;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			own_ip_q <= 32'd0;
		else if (cfg_valid && cfg_ready)
			own_ip_q <= cfg_own_ip;
	end

	arpc_cache u_cache (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.wr      (wr),
		.rd_ip   (rd_ip),
		.rd_mac  (rd_mac)
	);

	arpc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.own_ip    (own_ip_q),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_item  (req_item),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_item  (rsp_item),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_ip     (rd_ip),
		.rd_mac    (rd_mac),
		.wr        (wr)
	);

endmodule
